FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CHK_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

FILE: design/rbrc_pkg.sv
`timescale 1ns / 1ps

package rbrc_pkg;

   localparam int RING_BYTES = 4096;
   localparam int HDR_BYTES  = 8;
   localparam int SLOT_COUNT = RING_BYTES / HDR_BYTES;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int OFFSET_W   = $clog2(RING_BYTES);
   localparam int HDR_W      = 64;
   localparam int TOTAL_W    = 31;

   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_SUBMIT  = 2'd1;
   localparam logic [1:0] OP_POLL    = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_TOO_BIG  = 2'd1;
   localparam logic [1:0] STAT_NO_SPACE = 2'd2;

   typedef struct packed {
      logic               too_big;
      logic               no_space;
      logic [TOTAL_W-1:0] total;
   } space_type;

endpackage

FILE: design/ring_buffer_reserve_commit.sv
`timescale 1ns / 1ps

// Reserve/commit controller for a 4096-byte ring of 8-byte aligned records.
// Commands enter on start with the req_ ports; busy stays low, so a command
// is taken in every cycle that start is high. Opcode reserve checks size and
// free space against the consumer position given with it, writes a busy
// header and advances the producer; submit clears busy and may set discard
// in the header before the given data offset; poll reports whether the
// record at the consumer position is complete.
// Each command gives one response on the rsp_ ports, marked by rsp_valid for
// one cycle, after the s1 and response registers. One command per cycle is
// sustained: headers sit in a 512-entry memory with a registered read, and a
// header written in one cycle is forwarded to a command read in that same
// cycle. The receiver cannot stall; every response must be taken as shown.
// Reset clears the producer position and the pipeline; header contents are
// undefined until written.
module ring_buffer_reserve_commit import rbrc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [31:0]         req_request_size,
   input  logic signed [31:0]  req_owner_tag,
   input  logic [OFFSET_W-1:0] req_record_offset,
   input  logic                req_discard_flag,
   input  logic [63:0]         req_consumer_position,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [OFFSET_W-1:0] rsp_data_offset,
   output logic                rsp_data_ready,
   output logic [63:0]         rsp_producer_position
);

   logic              accept;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_slot;
   logic [HDR_W-1:0]  rd_data;

   logic              s1_valid_ff;
   logic [1:0]        s1_op_ff;
   logic [31:0]       s1_size_ff;
   logic [31:0]       s1_tag_ff;
   logic              s1_discard_ff;
   logic [63:0]       s1_cons_ff;
   logic [SLOT_W-1:0] s1_slot_ff;

   logic [63:0]       prod_ff, prod_in;
   logic              fwd_valid_ff;
   logic [SLOT_W-1:0] fwd_slot_ff;
   logic [HDR_W-1:0]  fwd_data_ff;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_slot;
   logic [HDR_W-1:0]  wr_data;
   logic [HDR_W-1:0]  hdr_word;
   space_type         space;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_doff_ff, rsp_doff_in;
   logic                rsp_ready_ff, rsp_ready_in;
   logic [63:0]         rsp_prod_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Header slot of the command: submit takes the slot before its data offset.
   always_comb begin
      rd_slot = '0;
      rd_en   = 1'b0;
      case (req_opcode)
         OP_SUBMIT: begin
            rd_slot = req_record_offset[OFFSET_W-1:3] - SLOT_W'(1);
            rd_en   = accept;
         end
         OP_POLL: begin
            rd_slot = req_consumer_position[OFFSET_W-1:3];
            rd_en   = accept;
         end
         default: begin
            rd_slot = '0;
            rd_en   = 1'b0;
         end
      endcase
   end

   rbrc_ram #(
      .WIDTH(HDR_W),
      .DEPTH(SLOT_COUNT)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_slot),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_slot),
      .rd_data(rd_data)
   );

   rbrc_space u_space (
      .size    (s1_size_ff),
      .producer(prod_ff),
      .consumer(s1_cons_ff),
      .check   (space)
   );

   // Take the header written last cycle; the memory read saw the old word.
   assign hdr_word = (fwd_valid_ff && (fwd_slot_ff == s1_slot_ff)) ? fwd_data_ff : rd_data;

   always_comb begin
      wr_en         = 1'b0;
      wr_slot       = s1_slot_ff;
      wr_data       = hdr_word;
      rsp_status_in = STAT_OK;
      rsp_doff_in   = '0;
      rsp_ready_in  = 1'b0;
      prod_in       = prod_ff;
      case (s1_op_ff)
         OP_RESERVE: begin
            if (space.too_big) begin
               rsp_status_in = STAT_TOO_BIG;
            end else if (space.no_space) begin
               rsp_status_in = STAT_NO_SPACE;
            end else begin
               wr_en       = s1_valid_ff;
               wr_slot     = prod_ff[OFFSET_W-1:3];
               wr_data     = {s1_tag_ff, 2'b10, s1_size_ff[29:0]};
               rsp_doff_in = prod_ff[OFFSET_W-1:0] + OFFSET_W'(HDR_BYTES);
               prod_in     = prod_ff + 64'(space.total);
            end
         end
         OP_SUBMIT: begin
            wr_en   = s1_valid_ff;
            wr_data = {hdr_word[63:32], 1'b0, hdr_word[30] | s1_discard_ff, hdr_word[29:0]};
         end
         OP_POLL: begin
            rsp_ready_in = (s1_cons_ff < prod_ff) && !hdr_word[31];
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prod_ff      <= '0;
      end else begin
         s1_valid_ff  <= accept;
         fwd_valid_ff <= wr_en;
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            prod_ff <= prod_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req_opcode;
         s1_size_ff    <= req_request_size;
         s1_tag_ff     <= req_owner_tag;
         s1_discard_ff <= req_discard_flag;
         s1_cons_ff    <= req_consumer_position;
         s1_slot_ff    <= rd_slot;
      end
      fwd_slot_ff <= wr_slot;
      fwd_data_ff <= wr_data;
      if (s1_valid_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_doff_ff   <= rsp_doff_in;
         rsp_ready_ff  <= rsp_ready_in;
         rsp_prod_ff   <= prod_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_data_offset       = rsp_doff_ff;
   assign rsp_data_ready        = rsp_ready_ff;
   assign rsp_producer_position = rsp_prod_ff;

endmodule

FILE: design/rbrc_ram.sv
`timescale 1ns / 1ps

module rbrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rbrc_space.sv
`timescale 1ns / 1ps

module rbrc_space import rbrc_pkg::*; (
   input  logic [31:0] size,
   input  logic [63:0] producer,
   input  logic [63:0] consumer,
   output space_type   check
);

   logic [TOTAL_W-1:0] total;
   logic [63:0]        used;
   logic [63:0]        room;

   // Round header plus payload up to the 8-byte record grain.
   assign total = (TOTAL_W'(size[29:0]) + TOTAL_W'(HDR_BYTES + 7)) & ~TOTAL_W'(7);
   assign used  = producer - consumer;
   assign room  = 64'(RING_BYTES) - 64'(total);

   always_comb begin
      check.total    = total;
      check.too_big  = size[31] || size[30] || (total > TOTAL_W'(RING_BYTES));
      // Valid only when the record fits the ring; too big wins otherwise.
      check.no_space = (used > 64'(RING_BYTES)) || (used > room);
   end

endmodule

FILE: design/rbrc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbrc_checker import rbrc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [1:0]          req_opcode,
   input logic                rsp_valid,
   input logic [1:0]          rsp_status,
   input logic [OFFSET_W-1:0] rsp_data_offset,
   input logic                rsp_data_ready
);

   // Every taken command is answered, and every response answers a taken command.
   `CHK_NEXT(a_rsp_follows, start && !busy, ##1 rsp_valid)
   `CHK_IMPLY(a_rsp_has_cmd, rsp_valid, $past(start && !busy, 2))
   // Only a reserve hands out a data offset; only a poll reports ready data.
   `CHK_IMPLY(a_doff_reserve, rsp_valid && ($past(req_opcode, 2) != OP_RESERVE),
              rsp_data_offset == '0)
   `CHK_IMPLY(a_ready_poll, rsp_valid && rsp_data_ready,
              ($past(req_opcode, 2) == OP_POLL) && (rsp_status == STAT_OK))

endmodule

bind ring_buffer_reserve_commit rbrc_checker u_rbrc_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rbrc_pkg::*;

   localparam logic [1:0]  OP_SPARE     = 2'd3;
   localparam logic [31:0] BUSY_MASK    = 32'h8000_0000;
   localparam logic [31:0] DISCARD_MASK = 32'h4000_0000;
   localparam int          BUSY_BIT     = 31;
   localparam logic [63:0] RING_SPAN    = 64'(RING_BYTES);
   localparam logic [63:0] ROUND_UP     = 64'(HDR_BYTES + 7);
   localparam logic [63:0] ALIGN_MASK   = ~64'd7;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [31:0]         size;
      logic signed [31:0]  tag;
      logic [OFFSET_W-1:0] offset;
      logic                discard;
      logic [63:0]         consumer;
   } command_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [OFFSET_W-1:0] offset;
      logic                ready;
      logic [63:0]         producer;
   } response_type;

   class ring_scoreboard;
      logic [63:0]      producer;
      logic [HDR_W-1:0] headers [SLOT_COUNT];
      bit               written [SLOT_COUNT];
      response_type     awaiting [$];
      int               failures;

      function new();
         producer = '0;
         failures = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function logic [SLOT_W-1:0] slot_of(logic [63:0] pos);
         return pos[OFFSET_W-1:3];
      endfunction

      // Predict the response to an accepted command and queue it.
      function response_type note_command(command_type c);
         response_type        r;
         logic [63:0]         total;
         logic [63:0]         used;
         logic [63:0]         avail;
         logic [SLOT_W-1:0]   slot;
         logic [OFFSET_W-1:0] hdr_pos;
         logic [31:0]         len;
         r = '0;
         r.status = STAT_OK;
         case (c.opcode)
            OP_RESERVE: begin
               total = ({32'd0, c.size} + ROUND_UP) & ALIGN_MASK;
               used  = producer - c.consumer;
               avail = (used > RING_SPAN) ? 64'd0 : RING_SPAN - used;
               if ((c.size & (BUSY_MASK | DISCARD_MASK)) != 0 || total > RING_SPAN) begin
                  r.status = STAT_TOO_BIG;
               end else if (avail < total) begin
                  r.status = STAT_NO_SPACE;
               end else begin
                  slot = slot_of(producer);
                  headers[slot] = {c.tag, c.size | BUSY_MASK};
                  written[slot] = 1'b1;
                  r.offset = OFFSET_W'(producer + 64'(HDR_BYTES));
                  producer = producer + total;
               end
            end
            OP_SUBMIT: begin
               hdr_pos = c.offset - OFFSET_W'(HDR_BYTES);
               slot = hdr_pos[OFFSET_W-1:3];
               len = headers[slot][31:0] & ~BUSY_MASK;
               if (c.discard) len = len | DISCARD_MASK;
               headers[slot] = {headers[slot][63:32], len};
            end
            OP_POLL: begin
               if (c.consumer < producer)
                  r.ready = !headers[slot_of(c.consumer)][BUSY_BIT];
            end
            default: ;
         endcase
         r.producer = producer;
         awaiting.push_back(r);
         return r;
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (awaiting.size() == 0) begin
            $error("response with no command outstanding");
            failures++;
            return;
         end
         want = awaiting.pop_front();
         compare("status", 64'(want.status), 64'(got.status));
         compare("data_offset", 64'(want.offset), 64'(got.offset));
         compare("data_ready", 64'(want.ready), 64'(got.ready));
         compare("producer_position", want.producer, got.producer);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_opcode;
   logic [31:0]         req_request_size;
   logic signed [31:0]  req_owner_tag;
   logic [OFFSET_W-1:0] req_record_offset;
   logic                req_discard_flag;
   logic [63:0]         req_consumer_position;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [OFFSET_W-1:0] rsp_data_offset;
   logic                rsp_data_ready;
   logic [63:0]         rsp_producer_position;

   ring_scoreboard sb = new();

   // consumer side of the stimulus: where the reader stands, record ends
   // it can advance to, and data offsets still waiting for a submit
   logic [63:0]         consumer_at;
   logic [63:0]         record_ends [$];
   logic [OFFSET_W-1:0] open_offsets [$];

   ring_buffer_reserve_commit dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_request_size      (req_request_size),
      .req_owner_tag         (req_owner_tag),
      .req_record_offset     (req_record_offset),
      .req_discard_flag      (req_discard_flag),
      .req_consumer_position (req_consumer_position),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_data_offset       (rsp_data_offset),
      .rsp_data_ready        (rsp_data_ready),
      .rsp_producer_position (rsp_producer_position)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response('{rsp_status, rsp_data_offset, rsp_data_ready,
                             rsp_producer_position});
   end

   task automatic drive_command(command_type c);
      response_type r;
      @(negedge clock);
      start                 = 1'b1;
      req_opcode            = c.opcode;
      req_request_size      = c.size;
      req_owner_tag         = c.tag;
      req_record_offset     = c.offset;
      req_discard_flag      = c.discard;
      req_consumer_position = c.consumer;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = sb.note_command(c);
      if (c.opcode == OP_RESERVE && r.status == STAT_OK) begin
         open_offsets.push_back(r.offset);
         record_ends.push_back(r.producer);
      end
   endtask

   task automatic issue(logic [1:0] op, logic [31:0] size, logic [31:0] tag,
                        logic [OFFSET_W-1:0] offset, logic discard, logic [63:0] consumer);
      command_type c;
      c = '{op, size, tag, offset, discard, consumer};
      drive_command(c);
   endtask

   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   function automatic command_type next_command();
      command_type         c;
      int                  pick;
      int                  idx;
      logic [OFFSET_W-1:0] hdr_pos;
      pick = $urandom_range(0, 99);
      // let the reader move past the oldest record now and then
      if (record_ends.size() > 0 && $urandom_range(0, 1) == 0)
         consumer_at = record_ends.pop_front();
      c.opcode   = OP_POLL;
      c.size     = $urandom;
      c.tag      = $urandom;
      c.offset   = OFFSET_W'($urandom);
      c.discard  = 1'($urandom_range(0, 1));
      c.consumer = consumer_at;
      if (pick < 40) begin
         c.opcode = OP_RESERVE;
         c.size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, RING_BYTES)
                                              : $urandom_range(0, 120);
      end else if (pick < 65) begin
         c.opcode = OP_SUBMIT;
         if (open_offsets.size() > 0) begin
            idx = $urandom_range(0, open_offsets.size() - 1);
            c.offset = open_offsets[idx];
            if ($urandom_range(0, 3) == 0)
               c.offset = c.offset + OFFSET_W'($urandom_range(1, 7));
            open_offsets.delete(idx);
         end
      end else if (pick < 85) begin
         if ($urandom_range(0, 3) == 0) c.consumer = consumer_at + $urandom_range(1, 7);
      end else begin
         c.opcode = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0: c.consumer = {$urandom, $urandom};
            1: c.consumer = consumer_at - $urandom_range(0, 2 * RING_BYTES);
            default: ;
         endcase
         if ($urandom_range(0, 1) == 0)
            c.size = $urandom_range(RING_BYTES - 16, RING_BYTES + 16);
      end
      // never touch a header slot that holds nothing yet
      hdr_pos = c.offset - OFFSET_W'(HDR_BYTES);
      if (c.opcode == OP_SUBMIT && !sb.written[hdr_pos[OFFSET_W-1:3]]) begin
         c.opcode   = OP_POLL;
         c.consumer = sb.producer;
      end
      if (c.opcode == OP_POLL && c.consumer < sb.producer && !sb.written[sb.slot_of(c.consumer)])
         c.consumer = sb.producer;
      return c;
   endfunction

   initial begin
      int idle_pct;
      int guard;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_opcode            = OP_POLL;
      req_request_size      = '0;
      req_owner_tag         = '0;
      req_record_offset     = '0;
      req_discard_flag      = 1'b0;
      req_consumer_position = '0;
      consumer_at           = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      issue(OP_POLL,    32'd0,         32'd0,         12'd0,     1'b0, 64'd0);
      issue(OP_RESERVE, 32'd0,         32'h8000_0000, 12'd0,     1'b0, 64'd0);
      issue(OP_POLL,    32'd0,         32'd0,         12'd0,     1'b0, 64'd0);
      issue(OP_SUBMIT,  32'd0,         32'd0,         12'd8,     1'b0, 64'd0);
      issue(OP_POLL,    32'd0,         32'd0,         12'd0,     1'b0, 64'd3);
      issue(OP_RESERVE, 32'h4000_0000, 32'd1,         12'd0,     1'b0, 64'd8);
      issue(OP_RESERVE, 32'h8000_0000, 32'd1,         12'd0,     1'b0, 64'd8);
      issue(OP_RESERVE, 32'hFFFF_FFFF, 32'd1,         12'd0,     1'b0, 64'd8);
      issue(OP_RESERVE, 32'd4089,      32'd1,         12'd0,     1'b0, 64'd8);
      issue(OP_RESERVE, 32'd4088,      32'd1,         12'd0,     1'b0, 64'd0);
      // exactly fills the ring
      issue(OP_RESERVE, 32'd4088,      32'h7FFF_FFFF, 12'd0,     1'b0, 64'd8);
      issue(OP_RESERVE, 32'd0,         32'd2,         12'd0,     1'b0, 64'd8);
      issue(OP_RESERVE, 32'd0,         32'd2,         12'd0,     1'b0, 64'd4112);
      issue(OP_RESERVE, 32'd0,         32'd2,         12'd0,     1'b0, 64'd0);
      issue(OP_SUBMIT,  32'd0,         32'd0,         12'd19,    1'b1, 64'd0);
      issue(OP_POLL,    32'd0,         32'd0,         12'd0,     1'b0, 64'd8);
      issue(OP_POLL,    32'd0,         32'd0,         12'd0,     1'b0, 64'd4104);
      issue(OP_SPARE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      issue(OP_RESERVE, 32'd4080,      32'h1234_5678, 12'd0,     1'b0, 64'd4104);
      issue(OP_SUBMIT,  32'd0,         32'd0,         12'd16,    1'b0, 64'd0);
      issue(OP_RESERVE, 32'd0,         32'hCAFE_0001, 12'd0,     1'b0, 64'd8192);
      issue(OP_POLL,    32'd0,         32'd0,         12'd0,     1'b0, 64'd8192);
      issue(OP_POLL,    32'd0,         32'd0,         12'd0,     1'b0, 64'd4104);

      consumer_at = sb.producer;
      record_ends.delete();
      open_offsets.delete();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 22 : (phase == 1) ? 59 : 0;
         for (int n = 0; n < 376; n++) begin
            // idle in about idle_pct percent of the cycles
            while ($urandom_range(0, 99) < idle_pct) hold_off(1);
            drive_command(next_command());
         end
         // drain the pipeline before the next phase
         hold_off(1);
         while (sb.awaiting.size() != 0) @(posedge clock);
      end

      guard = 0;
      while (sb.awaiting.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (sb.awaiting.size() != 0) begin
         $error("%0d responses never arrived", sb.awaiting.size());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: ring_buffer_reserve_commit.f
+incdir+design
design/rbrc_pkg.sv
design/rbrc_ram.sv
design/rbrc_space.sv
design/ring_buffer_reserve_commit.sv
design/rbrc_checker.sv
sim/testbench.sv
